### design/hls_pkg.sv
`default_nettype none

package hls_pkg;

    localparam int HOP_INTERVAL_W = 16;
    localparam int HOP_COUNT_W    = 5;
    localparam int SLOW_TIMEOUT_W = HOP_INTERVAL_W + HOP_COUNT_W;
    localparam int TIME_W         = 32;
    localparam int CHANNEL_W      = 5;
    localparam int RSSI_W         = 8;
    localparam int RSSI_ACC_W     = 13;
    localparam int RSSI_CNT_W     = 5;
    localparam int HISTORY_W      = 16;
    localparam int QBITS_W        = 4;
    localparam int PASS_CNT_W     = 10;

    localparam logic CFG_HOP_INTERVAL = 1'b0;
    localparam logic CFG_HOP_COUNT    = 1'b1;

    localparam logic [HOP_INTERVAL_W-1:0] HOP_INTERVAL_RESET = 16'd20;
    localparam logic [HOP_COUNT_W-1:0]    HOP_COUNT_RESET    = 5'd1;

    localparam logic [RSSI_CNT_W-1:0] RSSI_BLOCK = 5'd20;
    localparam logic [8:0]            RSSI_FLOOR = 9'd45;
    localparam logic [8:0]            RSSI_CEIL  = 9'd255;

    // acc / 21 == (acc * 6242) >> 17 for acc < 13107
    localparam logic [RSSI_ACC_W-1:0] RSSI_DIV_MULT  = 13'd6242;
    localparam int                    RSSI_DIV_SHIFT = 17;
    localparam int                    RSSI_PROD_W    = 2 * RSSI_ACC_W;

    localparam logic [PASS_CNT_W-1:0] PASS_LIMIT = 10'd500;
    localparam logic [PASS_CNT_W-1:0] LOW_SAT    = 10'd1023;
    localparam logic [HISTORY_W-1:0]  POOR_LEVEL = 16'd8;
    localparam logic [HISTORY_W-1:0]  GOOD_LEVEL = 16'd12;
    localparam logic [14:0]           QUALITY_MASK = 15'h7fff;

    typedef struct packed {
        logic [HOP_INTERVAL_W-1:0] hop_interval_ms;
        logic [HOP_COUNT_W-1:0]    hop_count;
        logic [SLOW_TIMEOUT_W-1:0] slow_timeout;
    } t_cfg;

    typedef struct packed {
        logic [TIME_W-1:0] now_ms;
        logic              packet_received;
        logic [RSSI_W-1:0] rssi_sample;
        logic              startup_done;
    } t_item;

    typedef struct packed {
        logic [TIME_W-1:0]     last_packet_time;
        logic [TIME_W-1:0]     last_rssi_time;
        logic [HISTORY_W-1:0]  quality_history;
        logic [CHANNEL_W-1:0]  missed_packets;
        logic                  seen_first_packet;
        logic [CHANNEL_W-1:0]  channel_index;
        logic [RSSI_ACC_W-1:0] rssi_accumulator;
        logic [RSSI_CNT_W-1:0] rssi_samples;
        logic [RSSI_W-1:0]     rssi_latest;
        logic [RSSI_W-1:0]     rssi_smoothed;
        logic [PASS_CNT_W-1:0] low_quality_passes;
        logic [PASS_CNT_W-1:0] recovery_passes;
        logic                  returning;
    } t_state;

    typedef struct packed {
        logic [CHANNEL_W-1:0] hop_channel;
        logic                 hop_now;
        logic [QBITS_W-1:0]   link_quality_bits;
        logic [HISTORY_W-1:0] link_quality_raw;
        logic [CHANNEL_W-1:0] miss_streak;
        logic [RSSI_W-1:0]    last_rssi;
        logic [RSSI_W-1:0]    smooth_rssi;
        logic                 return_trigger;
        logic                 return_active;
    } t_result;

endpackage

`default_nettype wire

### design/hls_pass.sv
`default_nettype none

module hls_pass
    import hls_pkg::*;
#(
    parameter int MAX_HOP_CHANNELS = 24
) (
    input  wire t_state  i_state,
    input  wire t_item   i_item,
    input  wire t_cfg    i_cfg,
    output t_state       o_state,
    output t_result      o_result
);

    t_state                 s;
    logic                   hop;
    logic                   trig;
    logic [TIME_W-1:0]      delta;
    logic [TIME_W-1:0]      iv_m1;
    logic [TIME_W-1:0]      iv_p1;
    logic [TIME_W-1:0]      slow_to;
    logic [RSSI_PROD_W-1:0] avg_prod;
    logic [8:0]             avg;
    logic [CHANNEL_W:0]     nxt;
    logic [QBITS_W-1:0]     qbits;

    always_comb begin
        s        = i_state;
        hop      = 1'b0;
        trig     = 1'b0;
        avg_prod = '0;
        avg      = '0;
        nxt      = '0;
        qbits    = '0;

        if (i_item.packet_received) begin
            s.last_packet_time  = i_item.now_ms;
            s.missed_packets    = '0;
            s.quality_history   = {s.quality_history[HISTORY_W-2:0], 1'b1};
            s.seen_first_packet = 1'b1;
            hop                 = 1'b1;
        end

        delta   = i_item.now_ms - s.last_packet_time;
        iv_m1   = {{(TIME_W-HOP_INTERVAL_W){1'b0}}, i_cfg.hop_interval_ms} - 32'd1;
        iv_p1   = {{(TIME_W-HOP_INTERVAL_W){1'b0}}, i_cfg.hop_interval_ms} + 32'd1;
        slow_to = {{(TIME_W-SLOW_TIMEOUT_W){1'b0}}, i_cfg.slow_timeout};

        // one RSSI sample per packet slot, in the air window
        if (s.missed_packets < 5'd2 && s.last_rssi_time != s.last_packet_time &&
            delta > iv_m1) begin
            s.last_rssi_time   = s.last_packet_time;
            s.rssi_latest      = i_item.rssi_sample;
            s.rssi_accumulator = s.rssi_accumulator
                               + {{(RSSI_ACC_W-RSSI_W){1'b0}}, i_item.rssi_sample};
            s.rssi_samples     = s.rssi_samples + 5'd1;
            if (s.rssi_samples > RSSI_BLOCK) begin
                avg_prod = RSSI_PROD_W'(s.rssi_accumulator) * RSSI_PROD_W'(RSSI_DIV_MULT);
                avg      = avg_prod[RSSI_DIV_SHIFT +: 9];
                if (avg < RSSI_FLOOR) begin
                    avg = RSSI_FLOOR;
                end
                if (avg > RSSI_CEIL) begin
                    avg = RSSI_CEIL;
                end
                // (8*s + 2*avg) / 8 == s + avg / 4
                s.rssi_smoothed    = s.rssi_smoothed + {1'b0, avg[8:2]};
                s.rssi_accumulator = '0;
                s.rssi_samples     = '0;
            end
        end

        if (s.seen_first_packet) begin
            if (s.missed_packets < i_cfg.hop_count && delta > iv_p1) begin
                s.quality_history  = {s.quality_history[HISTORY_W-2:0], 1'b0};
                hop                = 1'b1;
                s.missed_packets   = s.missed_packets + 5'd1;
                s.last_packet_time = s.last_packet_time
                    + {{(TIME_W-HOP_INTERVAL_W){1'b0}}, i_cfg.hop_interval_ms};
            end else if (s.missed_packets == i_cfg.hop_count && delta > slow_to) begin
                s.quality_history  = '0;
                hop                = 1'b1;
                s.rssi_smoothed    = '0;
                s.last_packet_time = i_item.now_ms;
            end

            if (s.quality_history < POOR_LEVEL && i_item.startup_done) begin
                if (s.low_quality_passes < LOW_SAT) begin
                    s.low_quality_passes = s.low_quality_passes + 10'd1;
                end
                if (s.low_quality_passes > PASS_LIMIT && !s.returning) begin
                    s.returning = 1'b1;
                    trig        = 1'b1;
                end
            end else begin
                s.low_quality_passes = '0;
                if (s.returning && s.quality_history > GOOD_LEVEL) begin
                    s.recovery_passes = s.recovery_passes + 10'd1;
                    if (s.recovery_passes > PASS_LIMIT) begin
                        s.returning       = 1'b0;
                        s.recovery_passes = '0;
                    end
                end else begin
                    s.recovery_passes = '0;
                end
            end
        end else if (delta > slow_to) begin
            // search hop before the first packet
            s.quality_history  = '0;
            s.last_packet_time = i_item.now_ms;
            hop                = 1'b1;
        end

        if (hop) begin
            nxt = {1'b0, s.channel_index} + 6'd1;
            if (nxt >= (CHANNEL_W+1)'(MAX_HOP_CHANNELS) || nxt >= {1'b0, i_cfg.hop_count}) begin
                nxt = '0;
            end
            s.channel_index = nxt[CHANNEL_W-1:0];
        end

        for (int k = 0; k < 15; k++) begin
            qbits = qbits + {3'b000, s.quality_history[k] & QUALITY_MASK[k]};
        end
    end

    assign o_state = s;

    assign o_result.hop_channel       = s.channel_index;
    assign o_result.hop_now           = hop;
    assign o_result.link_quality_bits = qbits;
    assign o_result.link_quality_raw  = s.quality_history;
    assign o_result.miss_streak       = s.missed_packets;
    assign o_result.last_rssi         = s.rssi_latest;
    assign o_result.smooth_rssi       = s.rssi_smoothed;
    assign o_result.return_trigger    = trig;
    assign o_result.return_active     = s.returning;

endmodule

`default_nettype wire

### design/hop_link_supervisor.sv
// Channel   Handshake                    Payload
// input     i_valid / o_ready            i_now_ms, i_packet_received, i_rssi_sample,
//                                        i_startup_done
// result    o_valid / i_ready            o_hop_channel .. o_return_active
// config    i_cfg_valid / o_cfg_ready    i_cfg_index, i_cfg_data
//
// An accepted request sits in the input register, runs one pass of logic, and its
// result is loaded into the result register. One request per cycle sustained while
// results are taken; all link state updates in the same edge as the result register.
// Reset restores interval 20, hop count 1 and clears all link state.
// A stalled result holds the pass; the input register still takes one more request.
`default_nettype none

module hop_link_supervisor
    import hls_pkg::*;
#(
    parameter int MAX_HOP_CHANNELS = 24
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_valid,
    output logic                      o_ready,
    input  wire  [TIME_W-1:0]         i_now_ms,
    input  wire                       i_packet_received,
    input  wire  [RSSI_W-1:0]         i_rssi_sample,
    input  wire                       i_startup_done,

    output logic                      o_valid,
    input  wire                       i_ready,
    output logic [CHANNEL_W-1:0]      o_hop_channel,
    output logic                      o_hop_now,
    output logic [QBITS_W-1:0]        o_link_quality_bits,
    output logic [HISTORY_W-1:0]      o_link_quality_raw,
    output logic [CHANNEL_W-1:0]      o_miss_streak,
    output logic [RSSI_W-1:0]         o_last_rssi,
    output logic [RSSI_W-1:0]         o_smooth_rssi,
    output logic                      o_return_trigger,
    output logic                      o_return_active,

    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire                       i_cfg_index,
    input  wire  [HOP_INTERVAL_W-1:0] i_cfg_data
);

    logic                      r_in_valid;
    t_item                     r_item;
    logic                      r_out_valid;
    t_result                   r_result;
    t_state                    r_state;
    t_state                    n_state;
    t_result                   n_result;
    logic [HOP_INTERVAL_W-1:0] r_hop_interval;
    logic [HOP_COUNT_W-1:0]    r_hop_count;
    logic [SLOW_TIMEOUT_W-1:0] r_slow_timeout;
    t_cfg                      w_cfg;
    logic                      w_advance;
    logic                      w_fire;

    assign w_advance   = !r_out_valid || i_ready;
    assign w_fire      = r_in_valid && w_advance;
    assign o_ready     = !r_in_valid || w_advance;
    assign o_cfg_ready = 1'b1;

    assign w_cfg.hop_interval_ms = r_hop_interval;
    assign w_cfg.hop_count       = r_hop_count;
    assign w_cfg.slow_timeout    = r_slow_timeout;

    hls_pass #(
        .MAX_HOP_CHANNELS(MAX_HOP_CHANNELS)
    ) u_pass (
        .i_state  (r_state),
        .i_item   (r_item),
        .i_cfg    (w_cfg),
        .o_state  (n_state),
        .o_result (n_result)
    );

    always_ff @(posedge i_clk) begin
        r_slow_timeout <= SLOW_TIMEOUT_W'(r_hop_interval) * SLOW_TIMEOUT_W'(r_hop_count);
        if (!i_rst_n) begin
            r_hop_interval <= HOP_INTERVAL_RESET;
            r_hop_count    <= HOP_COUNT_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_HOP_INTERVAL: r_hop_interval <= i_cfg_data;
                CFG_HOP_COUNT:    r_hop_count    <= i_cfg_data[HOP_COUNT_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_item.now_ms          <= i_now_ms;
            r_item.packet_received <= i_packet_received;
            r_item.rssi_sample     <= i_rssi_sample;
            r_item.startup_done    <= i_startup_done;
        end
        if (w_fire) begin
            r_result <= n_result;
        end
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_state     <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_out_valid <= 1'b1;
                r_state     <= n_state;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_valid             = r_out_valid;
    assign o_hop_channel       = r_result.hop_channel;
    assign o_hop_now           = r_result.hop_now;
    assign o_link_quality_bits = r_result.link_quality_bits;
    assign o_link_quality_raw  = r_result.link_quality_raw;
    assign o_miss_streak       = r_result.miss_streak;
    assign o_last_rssi         = r_result.last_rssi;
    assign o_smooth_rssi       = r_result.smooth_rssi;
    assign o_return_trigger    = r_result.return_trigger;
    assign o_return_active     = r_result.return_active;

endmodule

`default_nettype wire

### test/hls_link_checker.sv
`timescale 1ns / 1ps

module hls_link_checker
    import hls_pkg::*;
#(
    parameter int MAX_HOP_CHANNELS = 24
) (
    input  wire                       i_clk,
    input  wire                       i_rst_n,

    input  wire                       i_pass_valid,
    input  wire                       i_pass_ready,
    input  wire  [TIME_W-1:0]         i_now_ms,
    input  wire                       i_packet_received,
    input  wire  [RSSI_W-1:0]         i_rssi_sample,
    input  wire                       i_startup_done,

    input  wire                       i_status_valid,
    input  wire                       i_status_ready,
    input  wire  [CHANNEL_W-1:0]      i_hop_channel,
    input  wire                       i_hop_now,
    input  wire  [QBITS_W-1:0]        i_link_quality_bits,
    input  wire  [HISTORY_W-1:0]      i_link_quality_raw,
    input  wire  [CHANNEL_W-1:0]      i_miss_streak,
    input  wire  [RSSI_W-1:0]         i_last_rssi,
    input  wire  [RSSI_W-1:0]         i_smooth_rssi,
    input  wire                       i_return_trigger,
    input  wire                       i_return_active,

    input  wire                       i_cfg_valid,
    input  wire                       i_cfg_ready,
    input  wire                       i_cfg_index,
    input  wire  [HOP_INTERVAL_W-1:0] i_cfg_data,

    output int                        o_mismatches,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_returns,
    output int                        o_recoveries
);

    localparam logic [15:0] INTERVAL_AT_RESET = 16'd20;
    localparam logic [4:0]  CHANNELS_AT_RESET = 5'd1;
    localparam int SAMPLES_PER_BLOCK = 20;
    localparam int RSSI_LOW_CLAMP    = 45;
    localparam int RSSI_HIGH_CLAMP   = 255;
    localparam int RUN_LIMIT         = 500;
    localparam int RUN_CEIL          = 1023;
    localparam int POOR_MARK         = 8;
    localparam int GOOD_MARK         = 12;

    logic [15:0] interval_cfg;
    logic [4:0]  count_cfg;

    logic [31:0] pkt_time;
    logic [31:0] rssi_time;
    logic [15:0] history;
    logic [4:0]  missed;
    logic        linked;
    logic [4:0]  chan;
    logic [12:0] acc;
    logic [4:0]  nsamp;
    logic [7:0]  rssi_last;
    logic [7:0]  rssi_avg;
    logic [9:0]  poor_run;
    logic [9:0]  good_run;
    logic        homing;

    t_result status_due[$];

    function automatic t_result advance_link(input t_item p);
        logic [31:0] ivl;
        logic [31:0] slow;
        logic [31:0] delta;
        logic [31:0] avg;
        logic [4:0]  nxt;
        logic        hop;
        logic        trig;
        t_result     r;
        ivl  = 32'(interval_cfg);
        slow = ivl * 32'(count_cfg);
        hop  = 1'b0;
        trig = 1'b0;

        if (p.packet_received) begin
            pkt_time = p.now_ms;
            missed   = '0;
            history  = {history[14:0], 1'b1};
            linked   = 1'b1;
            hop      = 1'b1;
        end

        delta = p.now_ms - pkt_time;

        if (missed < 5'd2 && rssi_time != pkt_time && delta > ivl - 32'd1) begin
            rssi_time = pkt_time;
            rssi_last = p.rssi_sample;
            acc       = acc + 13'(p.rssi_sample);
            nsamp     = nsamp + 5'd1;
            if (nsamp > SAMPLES_PER_BLOCK) begin
                avg = 32'(acc) / 32'(nsamp);
                if (avg < RSSI_LOW_CLAMP) avg = RSSI_LOW_CLAMP;
                if (avg > RSSI_HIGH_CLAMP) avg = RSSI_HIGH_CLAMP;
                rssi_avg = 8'((32'(rssi_avg) * 32'd8 + avg * 32'd2) / 32'd8);
                acc      = '0;
                nsamp    = '0;
            end
        end

        if (linked) begin
            if (missed < count_cfg && delta > ivl + 32'd1) begin
                history  = {history[14:0], 1'b0};
                hop      = 1'b1;
                missed   = missed + 5'd1;
                pkt_time = pkt_time + ivl;
            end else if (missed == count_cfg && delta > slow) begin
                history  = '0;
                hop      = 1'b1;
                rssi_avg = '0;
                pkt_time = p.now_ms;
            end

            if (history < POOR_MARK && p.startup_done) begin
                if (poor_run != RUN_CEIL) poor_run = poor_run + 10'd1;
                if (poor_run > RUN_LIMIT && !homing) begin
                    homing = 1'b1;
                    trig   = 1'b1;
                    o_returns++;
                end
            end else begin
                poor_run = '0;
                if (homing && history > GOOD_MARK) begin
                    good_run = good_run + 10'd1;
                    if (good_run > RUN_LIMIT) begin
                        homing   = 1'b0;
                        good_run = '0;
                        o_recoveries++;
                    end
                end else begin
                    good_run = '0;
                end
            end
        end else if (delta > slow) begin
            history  = '0;
            pkt_time = p.now_ms;
            hop      = 1'b1;
        end

        if (hop) begin
            nxt = chan + 5'd1;
            if (int'(nxt) >= MAX_HOP_CHANNELS || nxt >= count_cfg) nxt = '0;
            chan = nxt;
        end

        r.hop_channel       = chan;
        r.hop_now           = hop;
        r.link_quality_bits = 4'($countones(history[14:0]));
        r.link_quality_raw  = history;
        r.miss_streak       = missed;
        r.last_rssi         = rssi_last;
        r.smooth_rssi       = rssi_avg;
        r.return_trigger    = trig;
        r.return_active     = homing;
        return r;
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            o_mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_item   pass_in;
        t_result want;
        if (!i_rst_n) begin
            interval_cfg = INTERVAL_AT_RESET;
            count_cfg    = CHANNELS_AT_RESET;
            pkt_time     = '0;
            rssi_time    = '0;
            history      = '0;
            missed       = '0;
            linked       = 1'b0;
            chan         = '0;
            acc          = '0;
            nsamp        = '0;
            rssi_last    = '0;
            rssi_avg     = '0;
            poor_run     = '0;
            good_run     = '0;
            homing       = 1'b0;
            status_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_HOP_INTERVAL: interval_cfg = i_cfg_data;
                    CFG_HOP_COUNT:    count_cfg    = i_cfg_data[4:0];
                endcase
            end
            if (i_pass_valid && i_pass_ready) begin
                pass_in.now_ms          = i_now_ms;
                pass_in.packet_received = i_packet_received;
                pass_in.rssi_sample     = i_rssi_sample;
                pass_in.startup_done    = i_startup_done;
                status_due.push_back(advance_link(pass_in));
            end
            if (i_status_valid && i_status_ready) begin
                if (status_due.size() == 0) begin
                    $error("link status returned with no request outstanding");
                    o_mismatches++;
                end else begin
                    want = status_due.pop_front();
                    check_field("hop_channel", want.hop_channel, i_hop_channel);
                    check_field("hop_now", want.hop_now, i_hop_now);
                    check_field("link_quality_bits", want.link_quality_bits,
                                i_link_quality_bits);
                    check_field("link_quality_raw", want.link_quality_raw,
                                i_link_quality_raw);
                    check_field("miss_streak", want.miss_streak, i_miss_streak);
                    check_field("last_rssi", want.last_rssi, i_last_rssi);
                    check_field("smooth_rssi", want.smooth_rssi, i_smooth_rssi);
                    check_field("return_trigger", want.return_trigger, i_return_trigger);
                    check_field("return_active", want.return_active, i_return_active);
                    o_checked++;
                end
            end
        end
        o_pending = status_due.size();
    end

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import hls_pkg::*;

    localparam int HOP_CHANNELS = 24;

    logic                      i_clk             = 1'b0;
    logic                      i_rst_n           = 1'b0;
    logic                      i_valid           = 1'b0;
    logic                      o_ready;
    logic [TIME_W-1:0]         i_now_ms          = '0;
    logic                      i_packet_received = 1'b0;
    logic [RSSI_W-1:0]         i_rssi_sample     = '0;
    logic                      i_startup_done    = 1'b0;
    logic                      o_valid;
    logic                      i_ready           = 1'b0;
    logic [CHANNEL_W-1:0]      o_hop_channel;
    logic                      o_hop_now;
    logic [QBITS_W-1:0]        o_link_quality_bits;
    logic [HISTORY_W-1:0]      o_link_quality_raw;
    logic [CHANNEL_W-1:0]      o_miss_streak;
    logic [RSSI_W-1:0]         o_last_rssi;
    logic [RSSI_W-1:0]         o_smooth_rssi;
    logic                      o_return_trigger;
    logic                      o_return_active;
    logic                      i_cfg_valid       = 1'b0;
    logic                      o_cfg_ready;
    logic                      i_cfg_index       = CFG_HOP_INTERVAL;
    logic [HOP_INTERVAL_W-1:0] i_cfg_data        = '0;

    int mismatches;
    int pending;
    int checked;
    int returns;
    int recoveries;

    int sender_idle_pct = 0;
    int recv_stall_pct  = 0;
    int passes_sent     = 0;
    int reg_writes      = 0;

    logic [31:0] clock_ms     = '0;
    logic [15:0] interval_set = 16'd20;
    logic [4:0]  channels_set = 5'd1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        i_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    hop_link_supervisor #(
        .MAX_HOP_CHANNELS(HOP_CHANNELS)
    ) i_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_ready             (o_ready),
        .i_now_ms            (i_now_ms),
        .i_packet_received   (i_packet_received),
        .i_rssi_sample       (i_rssi_sample),
        .i_startup_done      (i_startup_done),
        .o_valid             (o_valid),
        .i_ready             (i_ready),
        .o_hop_channel       (o_hop_channel),
        .o_hop_now           (o_hop_now),
        .o_link_quality_bits (o_link_quality_bits),
        .o_link_quality_raw  (o_link_quality_raw),
        .o_miss_streak       (o_miss_streak),
        .o_last_rssi         (o_last_rssi),
        .o_smooth_rssi       (o_smooth_rssi),
        .o_return_trigger    (o_return_trigger),
        .o_return_active     (o_return_active),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data)
    );

    hls_link_checker #(
        .MAX_HOP_CHANNELS(HOP_CHANNELS)
    ) u_checker (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_pass_valid        (i_valid),
        .i_pass_ready        (o_ready),
        .i_now_ms            (i_now_ms),
        .i_packet_received   (i_packet_received),
        .i_rssi_sample       (i_rssi_sample),
        .i_startup_done      (i_startup_done),
        .i_status_valid      (o_valid),
        .i_status_ready      (i_ready),
        .i_hop_channel       (o_hop_channel),
        .i_hop_now           (o_hop_now),
        .i_link_quality_bits (o_link_quality_bits),
        .i_link_quality_raw  (o_link_quality_raw),
        .i_miss_streak       (o_miss_streak),
        .i_last_rssi         (o_last_rssi),
        .i_smooth_rssi       (o_smooth_rssi),
        .i_return_trigger    (o_return_trigger),
        .i_return_active     (o_return_active),
        .i_cfg_valid         (i_cfg_valid),
        .i_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_mismatches        (mismatches),
        .o_pending           (pending),
        .o_checked           (checked),
        .o_returns           (returns),
        .o_recoveries        (recoveries)
    );

    task automatic send_pass(input logic [31:0] t, input logic pkt, input logic [7:0] rssi,
                             input logic st);
        if ($urandom_range(99) < sender_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        i_valid           <= 1'b1;
        i_now_ms          <= t;
        i_packet_received <= pkt;
        i_rssi_sample     <= rssi;
        i_startup_done    <= st;
        do @(posedge i_clk); while (!o_ready);
        passes_sent++;
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [15:0] value);
        settle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        if (idx == CFG_HOP_INTERVAL) interval_set = value;
        else channels_set = value[4:0];
        reg_writes++;
    endtask

    task automatic set_link(input logic [15:0] ivl, input logic [4:0] cnt);
        write_reg(CFG_HOP_INTERVAL, ivl);
        write_reg(CFG_HOP_COUNT, {11'd0, cnt});
    endtask

    // packet, mid-slot pass, pass at the air window
    task automatic good_link(input int slots, input logic st, input int rssi_lo,
                             input int rssi_hi, input int miss_pct);
        for (int s = 0; s < slots; s++) begin
            send_pass(clock_ms, ($urandom_range(99) >= miss_pct),
                      8'($urandom_range(rssi_hi, rssi_lo)), st);
            send_pass(clock_ms + $urandom_range(interval_set - 1, 1), 1'b0,
                      8'($urandom_range(rssi_hi, rssi_lo)), st);
            send_pass(clock_ms + interval_set, 1'b0,
                      8'($urandom_range(rssi_hi, rssi_lo)), st);
            clock_ms = clock_ms + interval_set + $urandom_range(1, 0);
        end
    endtask

    task automatic lost_link(input int passes, input logic st);
        logic [31:0] span;
        span = 32'(interval_set) * 32'(channels_set);
        for (int n = 0; n < passes; n++) begin
            case ($urandom_range(3))
                0:       clock_ms = clock_ms + $urandom_range(interval_set, 1);
                1:       clock_ms = clock_ms + interval_set + 32'd2;
                2:       clock_ms = clock_ms + span + 32'd1;
                default: clock_ms = clock_ms + $urandom_range(3 * span + 3, 0);
            endcase
            send_pass(clock_ms, 1'b0, 8'($urandom), st);
        end
    endtask

    task automatic noise(input int passes);
        for (int n = 0; n < passes; n++) begin
            clock_ms = $urandom;
            send_pass(clock_ms, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
        end
    endtask

    task automatic mixed_traffic(input int passes);
        int goal;
        int lo;
        int hi;
        goal = passes_sent + passes;
        while (passes_sent < goal) begin
            lo = $urandom_range(255);
            hi = $urandom_range(255, lo);
            case ($urandom_range(9))
                0, 1, 2, 3, 4, 5:
                    good_link($urandom_range(12, 3), 1'($urandom_range(1)), lo, hi, 20);
                6, 7:
                    lost_link($urandom_range(30, 3), 1'($urandom_range(1)));
                default:
                    noise($urandom_range(5, 1));
            endcase
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // search hops before first packet, sampling, fast and slow hops, time wrap
        send_pass(32'd0,          1'b0, 8'h00, 1'b0);
        send_pass(32'd21,         1'b0, 8'h80, 1'b0);
        send_pass(32'hFFFF_FFFF,  1'b0, 8'hFF, 1'b1);
        send_pass(32'd100,        1'b1, 8'hFF, 1'b1);
        send_pass(32'd110,        1'b0, 8'h55, 1'b1);
        send_pass(32'd120,        1'b0, 8'hFF, 1'b1);
        send_pass(32'd122,        1'b0, 8'hAA, 1'b1);
        send_pass(32'd141,        1'b0, 8'h00, 1'b1);
        send_pass(32'd150,        1'b1, 8'h00, 1'b0);
        send_pass(32'd170,        1'b0, 8'h00, 1'b0);
        send_pass(32'd170,        1'b1, 8'h7F, 1'b1);
        send_pass(32'hFFFF_FFF0,  1'b1, 8'h01, 1'b1);
        send_pass(32'h0000_0004,  1'b0, 8'hFE, 1'b1);
        send_pass(32'h0000_0006,  1'b0, 8'h33, 1'b0);
        clock_ms = 32'd200;

        // long outage saturates the poor-link count and fires the return,
        // then a clean link long enough to release it
        lost_link(1040, 1'b1);
        for (int k = 0; k < 6; k++) good_link(30, 1'b1, k * 42, k * 42 + 45, 0);

        sender_idle_pct = 81;
        set_link(16'd2, 5'd24);
        clock_ms = 32'hFFFF_FF00;
        mixed_traffic(50);

        sender_idle_pct = 0;
        recv_stall_pct  = 81;
        set_link(16'hFFFF, 5'd24);
        clock_ms = $urandom;
        mixed_traffic(50);

        sender_idle_pct = 28;
        recv_stall_pct  = 28;
        set_link(16'hFFFF, 5'd1);
        mixed_traffic(30);
        for (int k = 0; k < 2; k++) begin
            set_link(16'($urandom_range(400, 2)), 5'($urandom_range(24, 1)));
            mixed_traffic(25);
        end

        settle();
        $display("%0d link passes sent, %0d statuses checked, %0d register writes",
                 passes_sent, checked, reg_writes);
        $display("%0d return triggers and %0d link recoveries predicted", returns, recoveries);
        if (mismatches == 0 && pending == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("timeout with %0d statuses outstanding", pending);
        $display("end of test: mismatches");
        $finish;
    end

endmodule
